// ===== design/ie2sp_pkg.sv =====
package ie2sp_pkg;

    // Default number of key map slots.
    localparam int TABLE_DEPTH_DEF = 256;

    // Configuration register indexes and data width.
    localparam int CFG_W = 9;
    localparam logic CFG_EXIT_ON_ESCAPE = 1'b0;
    localparam logic CFG_TABLE_ENTRIES  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_SENT    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_ERROR   = 2'd2;
    localparam logic [1:0] STAT_QUIT    = 2'd3;

    // Packet opcodes.
    localparam logic [2:0] OP_DOWN   = 3'h1;
    localparam logic [2:0] OP_UP     = 3'h2;
    localparam logic [2:0] OP_X      = 3'h3;
    localparam logic [2:0] OP_Y      = 3'h4;
    localparam logic [2:0] OP_WHEEL  = 3'h5;
    localparam logic [2:0] OP_BUTTON = 3'h6;

    // Event types and codes.
    localparam logic [15:0] EV_SYN     = 16'd0;
    localparam logic [15:0] EV_KEY     = 16'd1;
    localparam logic [15:0] EV_REL     = 16'd2;
    localparam logic [15:0] EV_MSC     = 16'd4;
    localparam logic [15:0] REL_X      = 16'd0;
    localparam logic [15:0] REL_Y      = 16'd1;
    localparam logic [15:0] REL_SCROLL = 16'd8;
    localparam logic [15:0] SCAN_CODE  = 16'd4;
    localparam logic [15:0] KEY_ESC    = 16'd1;
    localparam logic [15:0] BTN_FIRST  = 16'h0110;
    localparam logic [15:0] BTN_LAST   = 16'h0113;

    // Key event values.
    localparam logic [31:0] KEY_RELEASE = 32'd0;
    localparam logic [31:0] KEY_PRESS   = 32'd1;
    localparam logic [31:0] KEY_REPEAT  = 32'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic               cmd;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
        logic [7:0]         entry_index;
        logic [15:0]        entry_src;
        logic [15:0]        entry_dest;
    } evt_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] opcode;
        logic [7:0] byte_hi;
        logic [7:0] byte_lo;
    } pkt_word_t;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dest;
    } key_entry_t;

endpackage

// ===== design/input_event_to_serial_packet.sv =====
// A load word is written to the key table in the idle state. Any other event word
// becomes a pending result that moves from the finish state into the output
// register; a key event that needs the table first searches it slot by slot.
// One word at a time: a new word is taken only in the idle state, and the linear
// search through the single read port of the key table sets the pace of key events.
// Reset sets state, output valid and the config registers, not the key table.
module input_event_to_serial_packet
    import ie2sp_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Event and table load words.
    input  logic             evt_valid,
    output logic             evt_stall,
    input  evt_word_t        evt,
    // Packet words.
    output logic             pkt_valid,
    input  logic             pkt_stall,
    output pkt_word_t        pkt,
    // Configuration write port.
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // AW addresses the table, CW holds a slot count up to TABLE_DEPTH.
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = AW + 1;
    localparam int IXW = (CW > 8) ? CW : 8;
    localparam int NW  = (CW > CFG_W) ? CW : CFG_W;

    state_t           state_reg, state_next;
    logic             exit_esc_reg;
    logic [CFG_W-1:0] tbl_entries_reg;
    logic [15:0]      code_reg, code_next;
    logic [2:0]       op_reg, op_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [AW-1:0]    idx_reg, idx_next;
    pkt_word_t        pend_reg, pend_next;
    pkt_word_t        pkt_reg, pkt_next;
    logic             pkt_valid_reg, pkt_valid_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    key_entry_t       mem_wdata;
    logic [AW-1:0]    mem_raddr;
    key_entry_t       mem_rdata;

    logic [IXW-1:0]   entry_ext;
    logic             entry_ok;
    logic [NW-1:0]    tbl_ext;
    logic [NW-1:0]    n_lim_w;
    logic [CW-1:0]    n_lim;
    logic [CW-1:0]    idx_inc;
    logic [31:0]      val_u;
    logic [15:0]      btn_off;
    logic             is_button;
    logic             search_go;
    logic             match;
    pkt_word_t        res;

    ie2sp_key_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_key_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers. The user writes only while the block is idle; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exit_esc_reg    <= 1'b1;
            tbl_entries_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXIT_ON_ESCAPE: exit_esc_reg    <= cfg_data[0];
                CFG_TABLE_ENTRIES:  tbl_entries_reg <= cfg_data;
                default:            exit_esc_reg    <= exit_esc_reg;
            endcase
        end
    end

    // A load slot beyond the table depth is dropped.
    assign entry_ext = IXW'(evt.entry_index);
    assign entry_ok  = entry_ext < IXW'(TABLE_DEPTH);
    assign mem_waddr = entry_ext[AW-1:0];
    assign mem_wdata = '{src: evt.entry_src, dest: evt.entry_dest};

    // The searched slot count is clamped to the table depth.
    assign tbl_ext = NW'(tbl_entries_reg);
    assign n_lim_w = (tbl_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : tbl_ext;
    assign n_lim   = n_lim_w[CW-1:0];

    assign idx_inc   = {1'b0, idx_reg} + CW'(1);
    assign val_u     = $unsigned(evt.ev_value);
    assign btn_off   = evt.ev_code - BTN_FIRST;
    assign is_button = (evt.ev_code >= BTN_FIRST) && (evt.ev_code <= BTN_LAST);

    // A zero source code marks a slot that never matches.
    assign match = (mem_rdata.src != 16'd0) && (mem_rdata.src == code_reg);

    // Immediate decode of an event word. A key press or release that is not a
    // mouse button sets search_go and is resolved by the table search.
    always_comb
    begin
        res        = '0;
        res.status = STAT_ERROR;
        search_go  = 1'b0;
        case (evt.ev_type)
            EV_SYN:
            begin
                res.status = STAT_IGNORED;
            end
            EV_MSC:
            begin
                if (evt.ev_code == SCAN_CODE)
                begin
                    res.status = STAT_IGNORED;
                end
            end
            EV_KEY:
            begin
                if (is_button)
                begin
                    if (val_u <= KEY_PRESS)
                    begin
                        res.status  = STAT_SENT;
                        res.opcode  = OP_BUTTON;
                        res.byte_hi = btn_off[7:0];
                        res.byte_lo = val_u[7:0];
                    end
                end
                else if (val_u == KEY_REPEAT)
                begin
                    res.status = STAT_IGNORED;
                end
                else if (val_u < KEY_REPEAT)
                begin
                    search_go = 1'b1;
                end
            end
            EV_REL:
            begin
                if (evt.ev_code == REL_X)
                begin
                    res.status  = STAT_SENT;
                    res.opcode  = OP_X;
                    res.byte_lo = val_u[7:0];
                end
                else if (evt.ev_code == REL_Y)
                begin
                    res.status  = STAT_SENT;
                    res.opcode  = OP_Y;
                    res.byte_lo = val_u[7:0];
                end
                else if (evt.ev_code == REL_SCROLL)
                begin
                    res.status  = STAT_SENT;
                    res.opcode  = OP_WHEEL;
                    res.byte_lo = val_u[7:0];
                end
            end
            default:
            begin
                res.status = STAT_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        op_reg   <= op_next;
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        pkt_reg  <= pkt_next;
    end

    // Sequencer. In search, the read data belongs to slot idx_reg and the next
    // slot is read in the same cycle, so one slot is checked per cycle.
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pkt_next       = pkt_reg;
        pkt_valid_next = pkt_valid_reg && pkt_stall;
        mem_we         = 1'b0;
        mem_raddr      = idx_inc[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (evt_valid)
                begin
                    if (evt.cmd)
                    begin
                        mem_we = entry_ok;
                    end
                    else if (search_go)
                    begin
                        code_next = evt.ev_code;
                        op_next   = (val_u == KEY_PRESS) ? OP_DOWN : OP_UP;
                        n_next    = n_lim;
                        idx_next  = '0;
                        if (n_lim == '0)
                        begin
                            pend_next        = '0;
                            pend_next.status = STAT_ERROR;
                            state_next       = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    else
                    begin
                        pend_next  = res;
                        state_next = S_FINISH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    pend_next = '0;
                    if (exit_esc_reg && (code_reg == KEY_ESC))
                    begin
                        pend_next.status = STAT_QUIT;
                    end
                    else
                    begin
                        pend_next.status  = STAT_SENT;
                        pend_next.opcode  = op_reg;
                        pend_next.byte_hi = mem_rdata.dest[15:8];
                        pend_next.byte_lo = mem_rdata.dest[7:0];
                    end
                    state_next = S_FINISH;
                end
                else if (idx_inc == n_reg)
                begin
                    pend_next        = '0;
                    pend_next.status = STAT_ERROR;
                    state_next       = S_FINISH;
                end
                else
                begin
                    idx_next = idx_inc[AW-1:0];
                end
            end
            S_FINISH:
            begin
                // Move the result once the output register is free or drains.
                if (!pkt_valid_reg || !pkt_stall)
                begin
                    pkt_next       = pend_reg;
                    pkt_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign evt_stall = (state_reg != S_IDLE);
    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

    // The search never reads past the clamped slot count.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> ({1'b0, idx_reg} < n_reg))
        else $error("search index beyond slot count");

    // A table load word finishes in its own cycle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall && evt.cmd) |=> (state_reg == S_IDLE))
        else $error("load word left the idle state");

    // A pending result moves into a free or draining output register at the next clock.
    a_finish_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && (!pkt_valid_reg || !pkt_stall))
        |=> (pkt_valid_reg && state_reg == S_IDLE))
        else $error("finished result not delivered");

    // Only a sent packet carries payload bytes.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && pkt_reg.status != STAT_SENT)
        |-> (pkt_reg.opcode == 3'd0 && pkt_reg.byte_hi == 8'd0 && pkt_reg.byte_lo == 8'd0))
        else $error("payload bytes on a non-sent status");

endmodule

// ===== design/ie2sp_key_table.sv =====
module ie2sp_key_table
    import ie2sp_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  key_entry_t               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output key_entry_t               rdata
);

    key_entry_t mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
